// File: src/assert_macros.svh
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// delayed implication
`define ASSERT_AFTER2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("assertion failed: two-cycle implication");

`endif

// File: src/kht_pkg.sv
package kht_pkg;

    localparam int KEY_W     = 10;
    localparam int KEY_EXT_W = 17;
    localparam int NODE_W    = 3;
    localparam int HOT_W     = 4;
    localparam int TIME_W    = 16;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // nodes a migration may target
    localparam logic [NODE_W:0] NODES = 4'd8;

    typedef enum logic [2:0] {
        CMD_ACCESS  = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_MIGRATE = 3'd2,
        CMD_SWEEP   = 3'd3,
        CMD_QUERY   = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP1     = 3'd0,
        CFG_STEP2     = 3'd1,
        CFG_STEP3     = 3'd2,
        CFG_STEP4     = 3'd3,
        CFG_MAX_HOT   = 3'd4,
        CFG_INIT_HOT  = 3'd5,
        CFG_THRESHOLD = 3'd6,
        CFG_IDLE_LIM  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
        logic [HOT_W-1:0]  hot;
        logic [TIME_W-1:0] last;
        logic [CNT_W-1:0]  cnt;
    } t_rec;

endpackage

// File: src/key_hotness_tracker.sv
// Key hotness tracker: one record per key slot in a single synchronous memory.
// Command channel: a transaction is taken at a clock edge with start high and
// busy low; cmd selects access, delete, migration done, decay sweep or query.
// Result channel: o_done is high for exactly one cycle with the result fields;
// the receiver cannot stall it, and it must take every result.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx at once; write
// only while busy is low and no result is pending.
// Timing: access, delete, migration done and query read the record at the
// accept edge into a read register, then modify it and write it back at the
// next edge; o_done rises at that edge and busy falls with it, so a new
// transaction is taken only once the last one is done. The registered read
// of the record memory followed by the write-back sets this pace.
// A decay sweep walks every slot through the same memory, o_done rising as
// busy falls.
// Reset: a clearing pass marks every slot invalid; busy is high throughout
// and config writes are still taken.
module key_hotness_tracker
    import kht_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_cmd,
    input  logic [KEY_W-1:0]     i_key_index,
    input  logic [TIME_W-1:0]    i_now,
    input  logic [NODE_W-1:0]    i_requester_node,
    input  logic [NODE_W-1:0]    i_target_node,
    input  logic                 i_migration_ok,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_done,
    output logic                 o_status,
    output logic [HOT_W-1:0]     o_hotness,
    output logic [NODE_W-1:0]    o_home_node,
    output logic [CNT_W-1:0]     o_acc_total,
    output logic                 o_remote_hot
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PTR_W = $clog2(ENTRIES + 1);
    localparam logic [PTR_W-1:0] PTR_END  = PTR_W'(ENTRIES);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } t_state;

    // configuration
    logic [TIME_W-1:0] r_step1, r_step2, r_step3, r_step4, r_idle_lim;
    logic [HOT_W-1:0]  r_max_hot, r_init_hot, r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step1     <= TIME_W'(10);
            r_step2     <= TIME_W'(60);
            r_step3     <= TIME_W'(300);
            r_step4     <= TIME_W'(1800);
            r_max_hot   <= HOT_W'(7);
            r_init_hot  <= HOT_W'(3);
            r_threshold <= HOT_W'(5);
            r_idle_lim  <= TIME_W'(10);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STEP1:     r_step1     <= i_cfg_data;
                CFG_STEP2:     r_step2     <= i_cfg_data;
                CFG_STEP3:     r_step3     <= i_cfg_data;
                CFG_STEP4:     r_step4     <= i_cfg_data;
                CFG_MAX_HOT:   r_max_hot   <= i_cfg_data[HOT_W-1:0];
                CFG_INIT_HOT:  r_init_hot  <= i_cfg_data[HOT_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[HOT_W-1:0];
                CFG_IDLE_LIM:  r_idle_lim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state             r_state;
    logic [PTR_W-1:0]   r_ptr;
    t_cmd               r_cmd;
    logic               r_inrange;
    logic [IDX_W-1:0]   r_addr;
    logic [TIME_W-1:0]  r_now;
    logic [NODE_W-1:0]  r_req;
    logic [NODE_W-1:0]  r_tgt;
    logic               r_ok;
    logic               r_sw_pend;
    logic [IDX_W-1:0]   r_sw_addr;
    logic               r_done;
    logic               r_status;
    logic [HOT_W-1:0]   r_hotness;
    logic [NODE_W-1:0]  r_node;
    logic [CNT_W-1:0]   r_count;
    logic               r_rhot;

    // record memory
    t_rec               r_mem [ENTRIES];
    t_rec               r_rd;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_rec               wr_data;

    logic [KEY_EXT_W-1:0] key_ext;
    logic                 key_inrange;

    assign key_ext     = {{(KEY_EXT_W-KEY_W){1'b0}}, i_key_index};
    assign key_inrange = key_ext < KEY_EXT_W'(ENTRIES);

    assign rd_en   = ((r_state == ST_IDLE) && start && key_inrange)
                   || ((r_state == ST_SWEEP) && (r_ptr != PTR_END));
    assign rd_addr = (r_state == ST_IDLE) ? key_ext[IDX_W-1:0] : r_ptr[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // read-modify-write datapath
    t_rec              base;
    logic [CNT_W-1:0]  cnt_n;
    logic [TIME_W-1:0] elapsed;
    logic [HOT_W-1:0]  decay;
    logic [HOT_W-1:0]  hot_dec;
    logic [HOT_W-1:0]  hot_n;
    logic [NODE_W-1:0] node_n;
    logic [TIME_W-1:0] sw_elapsed;
    logic              hit;
    logic              res_status;
    logic [HOT_W-1:0]  res_hot;
    logic [NODE_W-1:0] res_node;
    logic [CNT_W-1:0]  res_cnt;
    logic              res_rhot;

    always_comb begin
        hit  = r_inrange && r_rd.valid;
        base = r_rd;
        if (!r_rd.valid) begin
            base.node = '0;
            base.hot  = r_init_hot;
            base.last = r_now;
            base.cnt  = CNT_W'(1);
        end
        cnt_n   = (&base.cnt) ? base.cnt : base.cnt + CNT_W'(1);
        elapsed = r_now - base.last;
        priority if (elapsed < r_step1) begin
            decay = '0;
        end else if (elapsed < r_step2) begin
            decay = HOT_W'(1);
        end else if (elapsed < r_step3) begin
            decay = HOT_W'(2);
        end else if (elapsed < r_step4) begin
            decay = HOT_W'(3);
        end else begin
            decay = r_max_hot;
        end
        hot_dec = (decay >= base.hot) ? '0 : base.hot - decay;
        if (decay == '0) begin
            hot_dec = base.hot;
        end
        hot_n = (hot_dec < r_max_hot) ? hot_dec + HOT_W'(1) : hot_dec;

        node_n = (r_ok && ({1'b0, r_tgt} < NODES)) ? r_tgt : r_rd.node;
        sw_elapsed = r_now - r_rd.last;

        res_status = 1'b0;
        res_hot    = '0;
        res_node   = '0;
        res_cnt    = '0;
        res_rhot   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_addr;
        wr_data    = r_rd;

        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr[IDX_W-1:0];
                wr_data = '0;
            end
            ST_EXEC: begin
                unique case (r_cmd)
                    CMD_ACCESS: begin
                        if (!r_inrange) begin
                            res_status = 1'b1;
                        end else begin
                            wr_en        = 1'b1;
                            wr_data      = base;
                            wr_data.valid = 1'b1;
                            wr_data.hot  = hot_n;
                            wr_data.last = r_now;
                            wr_data.cnt  = cnt_n;
                            res_hot      = hot_n;
                            res_node     = base.node;
                            res_cnt      = cnt_n;
                            res_rhot     = (base.node != r_req) && (hot_n >= r_threshold);
                        end
                    end
                    CMD_DELETE: begin
                        if (!hit) begin
                            res_status = 1'b1;
                        end else begin
                            wr_en         = 1'b1;
                            wr_data.valid = 1'b0;
                        end
                    end
                    CMD_MIGRATE: begin
                        if (!hit) begin
                            res_status = 1'b1;
                        end else begin
                            wr_en        = 1'b1;
                            wr_data.node = node_n;
                            res_hot      = r_rd.hot;
                            res_node     = node_n;
                            res_cnt      = r_rd.cnt;
                        end
                    end
                    CMD_QUERY: begin
                        if (!hit) begin
                            res_status = 1'b1;
                        end else begin
                            res_hot  = r_rd.hot;
                            res_node = r_rd.node;
                            res_cnt  = r_rd.cnt;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SWEEP: begin
                wr_en   = r_sw_pend && r_rd.valid && (sw_elapsed > r_idle_lim);
                wr_addr = r_sw_addr;
                wr_data.hot  = (r_rd.hot != '0) ? r_rd.hot - HOT_W'(1) : r_rd.hot;
                wr_data.last = r_now;
            end
            default: ;
        endcase
    end

    // control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_ptr     <= '0;
            r_sw_pend <= 1'b0;
            r_done    <= 1'b0;
            r_status  <= 1'b0;
            r_hotness <= '0;
            r_node    <= '0;
            r_count   <= '0;
            r_rhot    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_ptr == PTR_LAST) begin
                        r_ptr   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_ptr <= r_ptr + PTR_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_cmd     <= t_cmd'(i_cmd);
                        r_inrange <= key_inrange;
                        r_addr    <= key_ext[IDX_W-1:0];
                        r_now     <= i_now;
                        r_req     <= i_requester_node;
                        r_tgt     <= i_target_node;
                        r_ok      <= i_migration_ok;
                        if (t_cmd'(i_cmd) == CMD_SWEEP) begin
                            r_ptr     <= '0;
                            r_sw_pend <= 1'b0;
                            r_state   <= ST_SWEEP;
                        end else begin
                            r_state <= ST_EXEC;
                        end
                    end
                end
                ST_EXEC: begin
                    r_done    <= 1'b1;
                    r_status  <= res_status;
                    r_hotness <= res_hot;
                    r_node    <= res_node;
                    r_count   <= res_cnt;
                    r_rhot    <= res_rhot;
                    r_state   <= ST_IDLE;
                end
                ST_SWEEP: begin
                    r_sw_pend <= (r_ptr != PTR_END);
                    r_sw_addr <= r_ptr[IDX_W-1:0];
                    if (r_ptr != PTR_END) begin
                        r_ptr <= r_ptr + PTR_W'(1);
                    end else begin
                        r_done    <= 1'b1;
                        r_status  <= 1'b0;
                        r_hotness <= '0;
                        r_node    <= '0;
                        r_count   <= '0;
                        r_rhot    <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_hotness      = r_hotness;
    assign o_home_node    = r_node;
    assign o_acc_total    = r_count;
    assign o_remote_hot   = r_rhot;

endmodule

// File: src/kht_checker.sv
`include "assert_macros.svh"

module kht_checker
    import kht_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic [2:0]           i_cmd,
    input logic                 o_done,
    input logic                 o_status,
    input logic [HOT_W-1:0]     o_hotness,
    input logic [NODE_W-1:0]    o_home_node,
    input logic [CNT_W-1:0]     o_acc_total,
    input logic                 o_remote_hot
);

    logic accept;
    logic accept_single;

    assign accept        = start && !busy;
    assign accept_single = accept && (i_cmd != CMD_SWEEP);

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    `ASSERT_AFTER2(a_single_latency, i_clk, i_rst_n, accept_single, o_done)
    `ASSERT_IMPLIES(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    `ASSERT_IMPLIES(a_miss_empty, i_clk, i_rst_n, o_done && o_status, (o_hotness == '0) && (o_home_node == '0) && (o_acc_total == '0) && !o_remote_hot)

endmodule

bind key_hotness_tracker kht_checker u_kht_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cmd          (i_cmd),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_hotness      (o_hotness),
    .o_home_node    (o_home_node),
    .o_acc_total    (o_acc_total),
    .o_remote_hot   (o_remote_hot)
);

// File: verif/tb_key_hotness_tracker.sv
`timescale 1ns / 100ps

module tb_key_hotness_tracker;
    import kht_pkg::*;

    localparam int ENTRIES  = 1024;
    localparam int KEY_POOL = 12;
    localparam int PHASES   = 8;
    localparam int PHASE_LEN = 175;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        logic [NODE_W-1:0] req;
        logic [NODE_W-1:0] tgt;
        logic              ok;
    } t_cmd_item;

    typedef struct packed {
        logic              status;
        logic [HOT_W-1:0]  hot;
        logic [NODE_W-1:0] node;
        logic [CNT_W-1:0]  cnt;
        logic              rhot;
    } t_key_report;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [2:0]           i_cmd = '0;
    logic [KEY_W-1:0]     i_key_index = '0;
    logic [TIME_W-1:0]    i_now = '0;
    logic [NODE_W-1:0]    i_requester_node = '0;
    logic [NODE_W-1:0]    i_target_node = '0;
    logic                 i_migration_ok = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_done;
    logic                 o_status;
    logic [HOT_W-1:0]     o_hotness;
    logic [NODE_W-1:0]    o_home_node;
    logic [CNT_W-1:0]     o_acc_total;
    logic                 o_remote_hot;

    key_hotness_tracker #(
        .ENTRIES(ENTRIES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_key_index      (i_key_index),
        .i_now            (i_now),
        .i_requester_node (i_requester_node),
        .i_target_node    (i_target_node),
        .i_migration_ok   (i_migration_ok),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_hotness        (o_hotness),
        .o_home_node      (o_home_node),
        .o_acc_total      (o_acc_total),
        .o_remote_hot     (o_remote_hot)
    );

    always #5 i_clk = ~i_clk;

    // tracker image
    logic              kvalid [ENTRIES];
    logic [NODE_W-1:0] knode  [ENTRIES];
    logic [HOT_W-1:0]  khot   [ENTRIES];
    logic [TIME_W-1:0] klast  [ENTRIES];
    logic [CNT_W-1:0]  kcnt   [ENTRIES];

    logic [TIME_W-1:0] step_secs [4];
    logic [HOT_W-1:0]  max_hot;
    logic [HOT_W-1:0]  init_hot;
    logic [HOT_W-1:0]  thr_hot;
    logic [TIME_W-1:0] idle_lim;

    t_cmd_item   pending_cmds [$];
    t_key_report expected_reports [$];
    t_cmd_item   cur;
    int          gap_left = 0;
    bit          bursty = 1'b0;
    int          err_total = 0;

    // stimulus shaping
    logic [KEY_W-1:0]  key_pool [KEY_POOL];
    logic [TIME_W-1:0] gen_last [ENTRIES];
    logic [TIME_W-1:0] wall = '0;

    function automatic int decay_of(logic [TIME_W-1:0] el);
        if (el < step_secs[0]) return 0;
        if (el < step_secs[1]) return 1;
        if (el < step_secs[2]) return 2;
        if (el < step_secs[3]) return 3;
        return int'(max_hot);
    endfunction

    function automatic t_key_report track_cmd(t_cmd_item it);
        t_key_report r;
        logic [TIME_W-1:0] el;
        int h;
        int d;
        r = '0;
        case (it.cmd)
            CMD_ACCESS: begin
                if (!kvalid[it.key]) begin
                    kvalid[it.key] = 1'b1;
                    knode[it.key]  = '0;
                    khot[it.key]   = init_hot;
                    klast[it.key]  = it.now;
                    kcnt[it.key]   = 1;
                end
                if (kcnt[it.key] != '1) kcnt[it.key] = kcnt[it.key] + 1;
                el = it.now - klast[it.key];
                d = decay_of(el);
                klast[it.key] = it.now;
                h = int'(khot[it.key]);
                if (d > 0) h = (d >= h) ? 0 : h - d;
                if (h < int'(max_hot)) h++;
                khot[it.key] = HOT_W'(h);
                r.hot  = khot[it.key];
                r.node = knode[it.key];
                r.cnt  = kcnt[it.key];
                r.rhot = (knode[it.key] != it.req) && (h >= int'(thr_hot));
            end
            CMD_DELETE: begin
                if (!kvalid[it.key]) r.status = 1'b1;
                else kvalid[it.key] = 1'b0;
            end
            CMD_MIGRATE, CMD_QUERY: begin
                if (!kvalid[it.key]) begin
                    r.status = 1'b1;
                end else begin
                    if (it.cmd == CMD_MIGRATE && it.ok && {1'b0, it.tgt} < NODES)
                        knode[it.key] = it.tgt;
                    r.hot  = khot[it.key];
                    r.node = knode[it.key];
                    r.cnt  = kcnt[it.key];
                end
            end
            CMD_SWEEP: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    el = it.now - klast[i];
                    if (kvalid[i] && el > idle_lim) begin
                        if (khot[i] != '0) khot[i] = khot[i] - 1'b1;
                        klast[i] = it.now;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) expected_reports.push_back(track_cmd(cur));
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cur = pending_cmds.pop_front();
                    i_cmd            <= cur.cmd;
                    i_key_index      <= cur.key;
                    i_now            <= cur.now;
                    i_requester_node <= cur.req;
                    i_target_node    <= cur.tgt;
                    i_migration_ok   <= cur.ok;
                    start            <= 1'b1;
                    if (bursty || $urandom_range(0, 3) == 0) gap_left = 0;
                    else gap_left = $urandom_range(0, 10);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            err_total++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_key_report e;
        if (i_rst_n && o_done) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual status %0h",
                         $time, o_status);
                err_total++;
            end else begin
                e = expected_reports.pop_front();
                check_field("status", CNT_W'(e.status), CNT_W'(o_status));
                check_field("hotness", CNT_W'(e.hot), CNT_W'(o_hotness));
                check_field("home_node", CNT_W'(e.node), CNT_W'(o_home_node));
                check_field("acc_total", e.cnt, o_acc_total);
                check_field("remote_hot", CNT_W'(e.rhot), CNT_W'(o_remote_hot));
            end
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_STEP1:     step_secs[0] = val;
            CFG_STEP2:     step_secs[1] = val;
            CFG_STEP3:     step_secs[2] = val;
            CFG_STEP4:     step_secs[3] = val;
            CFG_MAX_HOT:   max_hot  = val[HOT_W-1:0];
            CFG_INIT_HOT:  init_hot = val[HOT_W-1:0];
            CFG_THRESHOLD: thr_hot  = val[HOT_W-1:0];
            CFG_IDLE_LIM:  idle_lim = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int s1, int s2, int s3, int s4, int mh, int ih, int th, int il);
        cfg_write(CFG_STEP1, CFG_W'(s1));
        cfg_write(CFG_STEP2, CFG_W'(s2));
        cfg_write(CFG_STEP3, CFG_W'(s3));
        cfg_write(CFG_STEP4, CFG_W'(s4));
        cfg_write(CFG_MAX_HOT, {12'($urandom()), HOT_W'(mh)});
        cfg_write(CFG_INIT_HOT, {12'($urandom()), HOT_W'(ih)});
        cfg_write(CFG_THRESHOLD, {12'($urandom()), HOT_W'(th)});
        cfg_write(CFG_IDLE_LIM, CFG_W'(il));
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || expected_reports.size() != 0 || start || busy);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void add_cmd(logic [2:0] cmd, int key, int now, int req, int tgt, bit ok);
        t_cmd_item it;
        it.cmd = cmd;
        it.key = KEY_W'(key);
        it.now = TIME_W'(now);
        it.req = NODE_W'(req);
        it.tgt = NODE_W'(tgt);
        it.ok  = ok;
        pending_cmds.push_back(it);
    endfunction

    // a ladder or sweep threshold, give or take one
    function automatic logic [TIME_W-1:0] near_bound();
        int b;
        b = ($urandom_range(0, 4) == 4) ? int'(idle_lim) : int'(step_secs[$urandom_range(0, 3)]);
        return TIME_W'(b + int'($urandom_range(0, 2)) - 1);
    endfunction

    function automatic logic [TIME_W-1:0] time_step();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return TIME_W'($urandom_range(0, 20));
            4, 5, 6:    return near_bound();
            7, 8:       return TIME_W'($urandom_range(0, 3000));
            default:    return TIME_W'($urandom());
        endcase
    endfunction

    function automatic t_cmd_item random_cmd();
        t_cmd_item it;
        int pick;
        pick = $urandom_range(0, 99);
        it.key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom())
                                              : key_pool[$urandom_range(0, KEY_POOL - 1)];
        it.req = NODE_W'($urandom());
        it.tgt = NODE_W'($urandom());
        it.ok  = ($urandom_range(0, 3) != 0);
        wall = wall + time_step();
        it.now = wall;
        if (pick < 58) begin
            it.cmd = CMD_ACCESS;
            if ($urandom_range(0, 9) < 4) it.now = gen_last[it.key] + near_bound();
            gen_last[it.key] = it.now;
        end else if (pick < 70) begin
            it.cmd = CMD_QUERY;
        end else if (pick < 82) begin
            it.cmd = CMD_MIGRATE;
        end else if (pick < 90) begin
            it.cmd = CMD_DELETE;
        end else if (pick < 93) begin
            it.cmd = CMD_SWEEP;
        end else begin
            it.cmd = 3'(CMD_QUERY) + 3'($urandom_range(1, 3));
        end
        return it;
    endfunction

    task automatic configure(int ph);
        int s1;
        int s2;
        int s3;
        int s4;
        case (ph)
            0: set_regs(10, 60, 300, 1800, 7, 3, 5, 10);
            1: set_regs(0, 0, 0, 0, 15, 0, 0, 0);
            2: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 15, 15, 16'hFFFF);
            4: set_regs($urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom_range(1, 15), $urandom_range(0, 15),
                        $urandom_range(0, 15), $urandom());
            5: set_regs(1, 2, 3, 4, 15, 14, 1, 1);
            default: begin
                s1 = $urandom_range(0, 40);
                s2 = s1 + $urandom_range(0, 100);
                s3 = s2 + $urandom_range(0, 500);
                s4 = s3 + $urandom_range(0, 3000);
                set_regs(s1, s2, s3, s4, $urandom_range(1, 15), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 600));
            end
        endcase
    endtask

    initial begin
        step_secs[0] = 10;
        step_secs[1] = 60;
        step_secs[2] = 300;
        step_secs[3] = 1800;
        max_hot  = 7;
        init_hot = 3;
        thr_hot  = 5;
        idle_lim = 10;
        foreach (kvalid[i]) begin
            kvalid[i]   = 1'b0;
            knode[i]    = '0;
            khot[i]     = '0;
            klast[i]    = '0;
            kcnt[i]     = '0;
            gen_last[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // missing records
        add_cmd(CMD_QUERY, 0, 0, 0, 0, 1'b0);
        add_cmd(CMD_DELETE, 5, 0, 0, 0, 1'b0);
        add_cmd(CMD_MIGRATE, 5, 0, 0, 7, 1'b1);
        // create, then walk every rung of the decay ladder
        add_cmd(CMD_ACCESS, 0, 100, 0, 0, 1'b0);
        add_cmd(CMD_ACCESS, 0, 105, 7, 0, 1'b0);
        add_cmd(CMD_ACCESS, 0, 135, 3, 0, 1'b0);
        add_cmd(CMD_ACCESS, 0, 335, 3, 0, 1'b0);
        add_cmd(CMD_ACCESS, 0, 1335, 3, 0, 1'b0);
        add_cmd(CMD_ACCESS, 0, 11335, 3, 0, 1'b0);
        // time wrap and hotness saturation
        add_cmd(CMD_ACCESS, 1023, 65535, 7, 0, 1'b0);
        add_cmd(CMD_ACCESS, 1023, 4, 7, 0, 1'b0);
        add_cmd(CMD_ACCESS, 1023, 4, 7, 0, 1'b0);
        add_cmd(CMD_ACCESS, 1023, 4, 7, 0, 1'b0);
        add_cmd(CMD_ACCESS, 1023, 4, 7, 0, 1'b0);
        // migration ok and failed
        add_cmd(CMD_MIGRATE, 1023, 4, 0, 7, 1'b1);
        add_cmd(CMD_ACCESS, 1023, 6, 7, 0, 1'b0);
        add_cmd(CMD_MIGRATE, 1023, 6, 0, 3, 1'b0);
        add_cmd(CMD_QUERY, 1023, 6, 0, 0, 1'b0);
        add_cmd(CMD_SWEEP, 1, 100, 0, 0, 1'b0);
        add_cmd(CMD_QUERY, 0, 100, 0, 0, 1'b0);
        add_cmd(CMD_QUERY, 1023, 100, 0, 0, 1'b0);
        add_cmd(3'(CMD_QUERY) + 3'd1, 0, 0, 0, 0, 1'b0);
        add_cmd(3'(CMD_QUERY) + 3'd2, 1023, 65535, 7, 7, 1'b1);
        add_cmd(3'(CMD_QUERY) + 3'd3, 0, 0, 0, 0, 1'b0);
        add_cmd(CMD_DELETE, 0, 0, 0, 0, 1'b0);
        add_cmd(CMD_QUERY, 0, 0, 0, 0, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            configure(ph);
            bursty = (ph % 3 == 1);
            foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom());
            repeat (PHASE_LEN) pending_cmds.push_back(random_cmd());
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (err_total == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/kht_pkg.sv
src/key_hotness_tracker.sv
src/kht_checker.sv
verif/tb_key_hotness_tracker.sv
